// ----- src/modbus_rtu_response_deframer_macros.svh -----
// Assertion helpers used by the checker file.
// Both macros expect signals named clk and arst_n in the calling scope.
`ifndef MODBUS_RTU_RESPONSE_DEFRAMER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_DEFRAMER_MACROS_SVH

// Same-cycle implication.
`define MRRD_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MRRD_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mrrd_pkg.sv -----
`default_nettype none
package mrrd_pkg;

	localparam int BUFFER_DEPTH = 512;
	localparam int ADDR_W = $clog2(BUFFER_DEPTH);
	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam int LEN_W = 9;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [FILL_W-1:0] fill_t;
	typedef logic [LEN_W-1:0] len_t;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic [7:0] FC_READ_COILS = 8'h01;
	localparam logic [7:0] FC_READ_INPUTS = 8'h02;
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
	localparam logic [7:0] FC_WRITE_COIL = 8'h05;
	localparam logic [7:0] FC_WRITE_REG = 8'h06;
	localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
	localparam logic [7:0] FC_WRITE_REGS = 8'h10;

	localparam len_t READ_HDR_LEN = 9'd5;
	localparam len_t WRITE_FRAME_LEN = 9'd8;
	localparam len_t MAX_FRAME_LEN = 9'd260;
	localparam fill_t MIN_SCAN_FILL = FILL_W'(4);

	localparam logic [2:0] KIND_IDLE = 3'd0;
	localparam logic [2:0] KIND_STATUS = 3'd1;

	localparam logic [1:0] LAMP_NONE = 2'd0;
	localparam logic [1:0] LAMP_ONLINE = 2'd1;
	localparam logic [1:0] LAMP_CLEAN = 2'd2;
	localparam logic [1:0] LAMP_OFFLINE = 2'd3;

	function automatic logic is_read_code(logic [7:0] f);
		return (f >= FC_READ_COILS) && (f <= FC_READ_INPUT_REGS);
	endfunction

	function automatic logic is_write_code(logic [7:0] f);
		logic hit;
		case (f) inside
			FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// One byte of the reflected Modbus CRC.
	function automatic logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Circular buffer address; the offset never reaches the depth.
	function automatic addr_t addr_at(addr_t base, fill_t off);
		logic [ADDR_W:0] sum;
		sum = {1'b0, base} + (ADDR_W + 1)'(off);
		if (sum >= (ADDR_W + 1)'(BUFFER_DEPTH)) begin
			sum = sum - (ADDR_W + 1)'(BUFFER_DEPTH);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- src/modbus_rtu_response_deframer.sv -----
// Modbus RTU response deframer. Each input item is either a received byte (op 0)
// or a note that a command went out (op 1, sets the expected response kind).
// Bytes go into a circular buffer; after each byte the sequencer scans the front
// of the buffer, checking the CRC one byte per cycle through the single read port
// of the buffer memory. A command item only records the expected kind. A byte item
// starts a scan that checks candidate frames of need bytes (5 to 260), skips each
// byte that cannot start a frame or fails its CRC check, and ends by handing over the
// last result. Results leave through an output register; last marks the final frame
// found for a byte. in_stall stays high while a scan runs. The buffer needs no
// clearing after reset.
`default_nettype none
module modbus_rtu_response_deframer import mrrd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic op,
	input wire logic [7:0] rx_byte,
	input wire logic [2:0] expect_kind,
	output logic out_valid,
	input wire logic out_stall,
	output logic [7:0] func_code,
	output logic [8:0] frame_length,
	output logic [7:0] data_byte,
	output logic [1:0] lamp_status,
	output logic status_changed,
	output logic last
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_FUNC = 4'd2;
	localparam logic [3:0] S_LEN = 4'd3;
	localparam logic [3:0] S_CRC = 4'd4;
	localparam logic [3:0] S_CRL = 4'd5;
	localparam logic [3:0] S_CRH = 4'd6;
	localparam logic [3:0] S_D3 = 4'd7;
	localparam logic [3:0] S_EMIT = 4'd8;
	localparam logic [3:0] S_FLUSH = 4'd9;

	logic [7:0] mem_q [BUFFER_DEPTH];
	logic [7:0] rd_data_q;

	logic [3:0] state_q;
	addr_t head_q;
	fill_t fill_q;
	logic [2:0] kind_q;
	logic [1:0] lamp_q;
	logic [7:0] func_q;
	logic [7:0] cnt_q;
	logic [7:0] crc_lo_q;
	logic [7:0] d3_q;
	len_t need_q;
	len_t idx_q;
	logic [15:0] crc_q;

	logic pend_valid_q;
	logic [7:0] pend_func_q;
	len_t pend_len_q;
	logic [7:0] pend_data_q;
	logic [1:0] pend_lamp_q;
	logic pend_chg_q;

	logic out_valid_q;
	logic [7:0] out_func_q;
	len_t out_len_q;
	logic [7:0] out_data_q;
	logic [1:0] out_lamp_q;
	logic out_chg_q;
	logic out_last_q;

	logic in_fire;
	logic out_free;
	logic push_pend;
	logic emit_go;
	logic status_hit;
	logic [1:0] new_lamp;
	len_t rd_off;
	len_t idx_next;
	len_t crc_len;
	len_t read_need;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign emit_go = !pend_valid_q || out_free;
	assign push_pend = pend_valid_q && out_free && ((state_q == S_EMIT) || (state_q == S_FLUSH));
	assign idx_next = idx_q + 9'd1;
	assign crc_len = need_q - 9'd2;
	assign read_need = READ_HDR_LEN + len_t'(rd_data_q);

	assign status_hit = (kind_q == KIND_STATUS) && (func_q == FC_READ_INPUTS) && (cnt_q != 8'd0);

	always_comb begin
		new_lamp = lamp_q;
		if (status_hit) begin
			if (d3_q[0] && !d3_q[1]) begin
				new_lamp = LAMP_ONLINE;
			end else if (d3_q[0] && d3_q[1]) begin
				new_lamp = LAMP_CLEAN;
			end else begin
				new_lamp = LAMP_OFFLINE;
			end
		end
	end

	// Offset of the byte to fetch; the data shows up in the following state.
	always_comb begin
		rd_off = '0;
		unique case (state_q)
			S_CHECK: rd_off = 9'd1;
			S_FUNC: rd_off = is_read_code(rd_data_q) ? 9'd2 : 9'd0;
			S_CRC: rd_off = (idx_next < crc_len) ? idx_next : crc_len;
			S_CRL: rd_off = need_q - 9'd1;
			S_CRH: rd_off = 9'd3;
			default: rd_off = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire && !op && (fill_q < FILL_W'(BUFFER_DEPTH))) begin
			mem_q[addr_at(head_q, fill_q)] <= rx_byte;
		end
		rd_data_q <= mem_q[addr_at(head_q, FILL_W'(rd_off))];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			fill_q <= '0;
			kind_q <= KIND_IDLE;
			lamp_q <= LAMP_NONE;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (push_pend) begin
				out_valid_q <= 1'b1;
				out_last_q <= (state_q == S_FLUSH);
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (op) begin
							kind_q <= expect_kind;
						end else begin
							if (fill_q < FILL_W'(BUFFER_DEPTH)) begin
								fill_q <= fill_q + FILL_W'(1);
							end
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					state_q <= (fill_q < MIN_SCAN_FILL) ? S_FLUSH : S_FUNC;
				end
				S_FUNC: begin
					func_q <= rd_data_q;
					crc_q <= CRC_INIT;
					idx_q <= '0;
					if (is_read_code(rd_data_q)) begin
						state_q <= (fill_q < FILL_W'(READ_HDR_LEN)) ? S_FLUSH : S_LEN;
					end else if (is_write_code(rd_data_q)) begin
						need_q <= WRITE_FRAME_LEN;
						state_q <= (fill_q < FILL_W'(WRITE_FRAME_LEN)) ? S_FLUSH : S_CRC;
					end else begin
						head_q <= addr_at(head_q, FILL_W'(1));
						fill_q <= fill_q - FILL_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_LEN: begin
					cnt_q <= rd_data_q;
					need_q <= read_need;
					state_q <= (fill_q < FILL_W'(read_need)) ? S_FLUSH : S_CRC;
				end
				S_CRC: begin
					crc_q <= crc_step(crc_q, rd_data_q);
					idx_q <= idx_next;
					if (idx_next >= crc_len) begin
						state_q <= S_CRL;
					end
				end
				S_CRL: begin
					crc_lo_q <= rd_data_q;
					state_q <= S_CRH;
				end
				S_CRH: begin
					if ({rd_data_q, crc_lo_q} == crc_q) begin
						state_q <= S_D3;
					end else begin
						head_q <= addr_at(head_q, FILL_W'(1));
						fill_q <= fill_q - FILL_W'(1);
						state_q <= S_CHECK;
					end
				end
				S_D3: begin
					d3_q <= rd_data_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// The frame found before this one goes out first, now known not to be last.
					if (emit_go) begin
						pend_valid_q <= 1'b1;
						lamp_q <= new_lamp;
						kind_q <= KIND_IDLE;
						head_q <= addr_at(head_q, FILL_W'(need_q));
						fill_q <= fill_q - FILL_W'(need_q);
						state_q <= S_CHECK;
					end
				end
				S_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_func_q <= pend_func_q;
			out_len_q <= pend_len_q;
			out_data_q <= pend_data_q;
			out_lamp_q <= pend_lamp_q;
			out_chg_q <= pend_chg_q;
		end
		if ((state_q == S_EMIT) && emit_go) begin
			pend_func_q <= func_q;
			pend_len_q <= need_q;
			pend_data_q <= d3_q;
			pend_lamp_q <= new_lamp;
			pend_chg_q <= (new_lamp != lamp_q);
		end
	end

	assign out_valid = out_valid_q;
	assign func_code = out_func_q;
	assign frame_length = out_len_q;
	assign data_byte = out_data_q;
	assign lamp_status = out_lamp_q;
	assign status_changed = out_chg_q;
	assign last = out_last_q;

endmodule
`default_nettype wire

// ----- src/mrrd_checker.sv -----
`default_nettype none
`include "modbus_rtu_response_deframer_macros.svh"
module mrrd_checker import mrrd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic op,
	input wire logic [7:0] rx_byte,
	input wire logic [2:0] expect_kind,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] func_code,
	input wire logic [8:0] frame_length,
	input wire logic [7:0] data_byte,
	input wire logic [1:0] lamp_status,
	input wire logic status_changed,
	input wire logic last
);

	`MRRD_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(func_code) && $stable(frame_length) && $stable(last), "stalled result changed")
	`MRRD_IMPLIES(a_len_range, out_valid, (frame_length >= READ_HDR_LEN) && (frame_length <= MAX_FRAME_LEN), "frame length out of range")
	`MRRD_IMPLIES(a_write_len, out_valid && (func_code == FC_WRITE_COIL || func_code == FC_WRITE_REG || func_code == FC_WRITE_COILS || func_code == FC_WRITE_REGS), frame_length == WRITE_FRAME_LEN, "write response is not eight bytes")
	`MRRD_IMPLIES(a_change_status, out_valid && status_changed, (lamp_status != LAMP_NONE) && (func_code == FC_READ_INPUTS), "status changed by a frame that cannot set it")

endmodule

bind modbus_rtu_response_deframer mrrd_checker u_mrrd_checker (.*);
`default_nettype wire

// ----- tb/tb_modbus_rtu_response_deframer.sv -----
`timescale 1ns / 1ps
module tb_modbus_rtu_response_deframer;
	import mrrd_pkg::*;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_CMD = 1'b1;

	localparam logic [2:0] KIND_CLEAN = 3'd2;
	localparam logic [2:0] KIND_FLASH = 3'd3;
	localparam logic [2:0] KIND_FLASH_5S = 3'd4;
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam int STORE_DEPTH = BUFFER_DEPTH;
	localparam int RESULT_CAP = 52;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 600;
	localparam int HOLD_CYCLES = 900;
	localparam int RANDOM_ITEMS = 100;
	localparam int RANDOM_FRAMES = 40;
	localparam logic [7:0] DIR_ADDR = 8'hF7;

	localparam logic [7:0] CODE_LIST [8] = '{FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING,
		FC_READ_INPUT_REGS, FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		logic [7:0] func;
		len_t length;
		logic [7:0] data;
		logic [1:0] lamp;
		logic changed;
		logic last;
	} frame_res_t;

	typedef enum logic [1:0] {ROW_CMD, ROW_FRAME, ROW_NOISE, ROW_BAD} row_kind_e;

	typedef struct packed {
		row_kind_e kind;
		logic [7:0] func;
		logic [7:0] count;
		logic [7:0] d3;
		logic [2:0] cmd;
		logic typed;
		len_t exp_len;
		logic [1:0] exp_lamp;
		logic exp_changed;
	} dir_row_t;

	// Status reads walk ONLINE, CLEAN, OFFLINE; later frames must leave the status alone
	// until the long read at the end of the frame rows brings it back to ONLINE.
	localparam dir_row_t DIRECTED_ROWS [31] = '{
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h01, KIND_IDLE, 1'b1, 9'd6, LAMP_ONLINE, 1'b1},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h03, KIND_IDLE, 1'b1, 9'd6, LAMP_CLEAN, 1'b1},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h02, KIND_IDLE, 1'b1, 9'd6, LAMP_OFFLINE, 1'b1},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h00, KIND_IDLE, 1'b1, 9'd6, LAMP_OFFLINE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h01, KIND_IDLE, 1'b1, 9'd6, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd0, 8'h00, KIND_IDLE, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_HOLDING, 8'd2, 8'hFF, KIND_IDLE, 1'b1, 9'd7, LAMP_OFFLINE, 1'b0},
		'{ROW_FRAME, FC_READ_COILS, 8'd1, 8'hFE, KIND_IDLE, 1'b1, 9'd6, LAMP_OFFLINE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUT_REGS, 8'd2, 8'h80, KIND_IDLE, 1'b1, 9'd7, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_CLEAN, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_WRITE_COIL, 8'd0, 8'hAA, KIND_IDLE, 1'b1, 9'd8, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_FLASH, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_WRITE_REG, 8'd0, 8'h55, KIND_IDLE, 1'b1, 9'd8, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_SPARE_LO, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_WRITE_COILS, 8'd0, 8'h01, KIND_IDLE, 1'b1, 9'd8, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_SPARE_HI, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd1, 8'h01, KIND_IDLE, 1'b1, 9'd6, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_FLASH_5S, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_WRITE_REGS, 8'd0, 8'h00, KIND_IDLE, 1'b1, 9'd8, LAMP_OFFLINE, 1'b0},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_STATUS, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_READ_INPUTS, 8'd255, 8'h01, KIND_IDLE, 1'b1, 9'd260, LAMP_ONLINE, 1'b1},
		'{ROW_CMD, 8'h00, 8'd0, 8'h00, KIND_IDLE, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_BAD, FC_READ_HOLDING, 8'd1, 8'h42, KIND_IDLE, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_NOISE, 8'h00, 8'd0, 8'h00, KIND_IDLE, 1'b0, 9'd0, LAMP_NONE, 1'b0},
		'{ROW_FRAME, FC_WRITE_REG, 8'd0, 8'h33, KIND_IDLE, 1'b0, 9'd0, LAMP_NONE, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic op = OP_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic [2:0] expect_kind = KIND_IDLE;
	logic out_stall = 1'b0;
	wire logic in_stall;
	wire logic out_valid;
	wire logic [7:0] func_code;
	wire logic [8:0] frame_length;
	wire logic [7:0] data_byte;
	wire logic [1:0] lamp_status;
	wire logic status_changed;
	wire logic last;

	modbus_rtu_response_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.rx_byte(rx_byte),
		.expect_kind(expect_kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.func_code(func_code),
		.frame_length(frame_length),
		.data_byte(data_byte),
		.lamp_status(lamp_status),
		.status_changed(status_changed),
		.last(last)
	);

	always #10 clk = ~clk;

	// Mirror of the receive buffer and the response state.
	logic [7:0] rx_mirror [STORE_DEPTH];
	int unsigned mirror_head = 0;
	int unsigned mirror_fill = 0;
	logic [2:0] pending_kind = KIND_IDLE;
	logic [1:0] lamp_state = LAMP_NONE;
	frame_res_t expected_frames[$];

	int error_count = 0;
	int items_sent = 0;
	int frames_checked = 0;
	int frames_due = 0;
	int longest_frame = 0;
	int cycle_count = 0;
	int gap_pct = 25;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;
	int hold_cnt = 0;
	int burst_cnt = 0;
	int calm_cnt = 0;
	frame_res_t due_frame;

	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("MISMATCH at frame %0d: %s got 0x%0h, want 0x%0h", frames_checked, what, got, want);
	endtask

	function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] mirror_at(int unsigned off);
		return rx_mirror[(mirror_head + off) % STORE_DEPTH];
	endfunction

	function automatic void drop_front(int unsigned n);
		if (n > mirror_fill) begin
			n = mirror_fill;
		end
		mirror_head = (mirror_head + n) % STORE_DEPTH;
		mirror_fill -= n;
	endfunction

	// Appends one byte and pulls complete, CRC-clean frames off the front, up to RESULT_CAP per byte.
	task automatic deframe_byte(input logic [7:0] b, output int produced);
		int unsigned need;
		logic [7:0] code;
		logic [7:0] inputs;
		logic [15:0] crc;
		logic [15:0] sent_crc;
		logic [1:0] prev;
		frame_res_t r;
		produced = 0;
		if (mirror_fill < STORE_DEPTH) begin
			rx_mirror[(mirror_head + mirror_fill) % STORE_DEPTH] = b;
			mirror_fill++;
		end
		while (mirror_fill >= 4 && produced < RESULT_CAP) begin
			code = mirror_at(1);
			if (code >= FC_READ_COILS && code <= FC_READ_INPUT_REGS) begin
				if (mirror_fill < 5) begin
					break;
				end
				need = 5 + mirror_at(2);
			end else if (code == FC_WRITE_COIL || code == FC_WRITE_REG
					|| code == FC_WRITE_COILS || code == FC_WRITE_REGS) begin
				need = 8;
			end else begin
				drop_front(1);
				continue;
			end
			if (mirror_fill < need) begin
				break;
			end
			crc = CRC_INIT;
			for (int unsigned i = 0; i < need - 2; i++) begin
				crc = crc_fold(crc, mirror_at(i));
			end
			sent_crc = {mirror_at(need - 1), mirror_at(need - 2)};
			if (sent_crc != crc) begin
				drop_front(1);
				continue;
			end
			prev = lamp_state;
			if (pending_kind == KIND_STATUS && code == FC_READ_INPUTS && mirror_at(2) != 8'd0) begin
				inputs = mirror_at(3);
				case (inputs[1:0])
					2'b01: lamp_state = LAMP_ONLINE;
					2'b11: lamp_state = LAMP_CLEAN;
					default: lamp_state = LAMP_OFFLINE;
				endcase
			end
			r.func = code;
			r.length = len_t'(need);
			r.data = mirror_at(3);
			r.lamp = lamp_state;
			r.changed = (lamp_state != prev);
			r.last = 1'b0;
			expected_frames.push_back(r);
			produced++;
			frames_due++;
			drop_front(need);
			pending_kind = KIND_IDLE;
		end
		if (produced > 0) begin
			expected_frames[expected_frames.size() - 1].last = 1'b1;
		end
	endtask

	// Offers one item, optionally after an idle burst, and returns once it is taken.
	task automatic send_item(input logic o, input logic [7:0] b, input logic [2:0] k,
			output int produced);
		int gap;
		gap = 0;
		if (!quiet && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			gap = $urandom_range(11, 1);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		rx_byte <= b;
		expect_kind <= k;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		produced = 0;
		if (o == OP_CMD) begin
			pending_kind = k;
		end else begin
			deframe_byte(b, produced);
		end
	endtask

	// Returns the number of frames found on the final byte.
	task automatic send_bytes(input byte_q_t bytes, output int produced);
		int n;
		produced = 0;
		foreach (bytes[i]) begin
			send_item(OP_BYTE, bytes[i], 3'($urandom_range(7)), n);
			produced = n;
		end
	endtask

	function automatic byte_q_t build_frame(logic [7:0] addr, logic [7:0] code, logic [7:0] count,
			logic [7:0] d3, bit scramble);
		byte_q_t q;
		logic [15:0] crc;
		q = {};
		q.push_back(addr);
		q.push_back(code);
		if (code >= FC_READ_COILS && code <= FC_READ_INPUT_REGS) begin
			q.push_back(count);
			if (count != 8'd0) begin
				q.push_back(d3);
			end
			for (int i = 1; i < int'(count); i++) begin
				q.push_back(scramble ? 8'($urandom) : 8'(i));
			end
		end else begin
			q.push_back(scramble ? 8'($urandom) : 8'h00);
			q.push_back(d3);
			q.push_back(scramble ? 8'($urandom) : 8'hFF);
			q.push_back(scramble ? 8'($urandom) : 8'h00);
		end
		crc = CRC_INIT;
		foreach (q[i]) begin
			crc = crc_fold(crc, q[i]);
		end
		q.push_back(crc[7:0]);
		q.push_back(crc[15:8]);
		return q;
	endfunction

	// Output side: checks each result and idles in random bursts.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frames_checked++;
			if (frame_length > longest_frame) begin
				longest_frame = frame_length;
			end
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected frame, func_code", func_code, 0);
			end else begin
				due_frame = expected_frames.pop_front();
				if (func_code !== due_frame.func)
					report_mismatch("func_code", func_code, due_frame.func);
				if (frame_length !== due_frame.length)
					report_mismatch("frame_length", frame_length, due_frame.length);
				if (data_byte !== due_frame.data)
					report_mismatch("data_byte", data_byte, due_frame.data);
				if (lamp_status !== due_frame.lamp)
					report_mismatch("lamp_status", lamp_status, due_frame.lamp);
				if (status_changed !== due_frame.changed)
					report_mismatch("status_changed", status_changed, due_frame.changed);
				if (last !== due_frame.last)
					report_mismatch("last", last, due_frame.last);
			end
		end
		if (hold_go) begin
			hold_go = 1'b0;
			hold_cnt = HOLD_CYCLES;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (quiet) begin
			out_stall <= 1'b0;
		end else if (burst_cnt > 0) begin
			burst_cnt--;
			out_stall <= 1'b1;
		end else if (calm_cnt > 0) begin
			calm_cnt--;
			out_stall <= 1'b0;
		end else if ($urandom_range(99) < 20) begin
			burst_cnt = $urandom_range(10, 0);
			out_stall <= 1'b1;
		end else if ($urandom_range(99) < 5) begin
			calm_cnt = $urandom_range(60, 20);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d frames outstanding",
				cycle_count, expected_frames.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		dir_row_t row;
		byte_q_t frame;
		int produced;
		int start_items;
		int start_due;
		int random_items;
		int pick;
		int idx;
		logic [7:0] code;
		logic [7:0] count;
		bit hold_done;
		bit pause_done;

		hold_done = 1'b0;
		pause_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 31; r++) begin
			row = DIRECTED_ROWS[r];
			case (row.kind)
				ROW_CMD: begin
					send_item(OP_CMD, 8'($urandom), row.cmd, produced);
				end
				ROW_FRAME: begin
					frame = build_frame(DIR_ADDR, row.func, row.count, row.d3, 1'b0);
					send_bytes(frame, produced);
					if (row.typed) begin
						if (produced != 1) begin
							report_mismatch("frames found for directed frame", produced, 1);
						end else begin
							expected_frames[expected_frames.size() - 1] = '{func: row.func,
								length: row.exp_len, data: row.d3, lamp: row.exp_lamp,
								changed: row.exp_changed, last: 1'b1};
						end
					end
				end
				ROW_BAD: begin
					frame = build_frame(DIR_ADDR, row.func, row.count, row.d3, 1'b0);
					frame[frame.size() - 1] ^= 8'h80;
					send_bytes(frame, produced);
				end
				default: begin
					send_bytes('{8'h00, 8'hFF, 8'h80, 8'h7F}, produced);
				end
			endcase
		end
		while (expected_frames.size() != 0) @(posedge clk);

		start_items = items_sent;
		start_due = frames_due;
		random_items = 0;
		while (random_items < RANDOM_ITEMS || frames_due - start_due < RANDOM_FRAMES) begin
			gap_pct = ($urandom_range(99) < 30) ? 0 : 30;
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_item(OP_CMD, 8'($urandom),
					($urandom_range(1) != 0) ? KIND_STATUS : 3'($urandom_range(7)), produced);
			end else if (pick < 22) begin
				repeat ($urandom_range(4, 1)) begin
					send_item(OP_BYTE, 8'($urandom), 3'($urandom_range(7)), produced);
				end
			end else begin
				code = CODE_LIST[$urandom_range(7)];
				count = ($urandom_range(39) == 0) ? 8'd255 : 8'($urandom_range(6));
				if (code == FC_READ_INPUTS && $urandom_range(99) < 50) begin
					send_item(OP_CMD, 8'($urandom), KIND_STATUS, produced);
				end
				frame = build_frame(8'($urandom), code, count, 8'($urandom), 1'b1);
				// A share of the frames is damaged: a flipped bit or a lost tail.
				if (pick < 34) begin
					if ($urandom_range(1) != 0) begin
						idx = $urandom_range(frame.size() - 1);
						frame[idx] ^= 8'(1 << $urandom_range(7));
					end else begin
						repeat ($urandom_range(2, 1)) void'(frame.pop_back());
					end
				end
				send_bytes(frame, produced);
			end
			random_items = items_sent - start_items;
			if (!hold_done && random_items >= 40) begin
				hold_done = 1'b1;
				hold_go = 1'b1;
			end
			if (!pause_done && random_items >= 60 && hold_cnt == 0 && !hold_go) begin
				pause_done = 1'b1;
				while (expected_frames.size() != 0) @(posedge clk);
			end
			if (random_items >= 80) begin
				quiet = 1'b1;
			end
		end
		in_valid <= 1'b0;

		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d random), checked %0d frames, longest %0d bytes.",
			items_sent, random_items, frames_checked, longest_frame);
		$display("Covered all function codes, status reads, corrupt frames, noise and back-pressure.");
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
